@@ sv/rwtc_pkg.sv @@
// ----------------------------------------------------------------------------
// rwtc_pkg - shared types and constants of the row window track classifier
// Feature widths, class and register codes, default geometry, bit counting.
// ----------------------------------------------------------------------------
`default_nettype none

package rwtc_pkg;

   // default window geometry
   localparam int DEF_WINDOW_ROWS  = 30;
   localparam int DEF_SENSOR_COUNT = 8;
   localparam int SENSOR_MAX       = 16;

   // centroid classes
   localparam int CLASS_COUNT = 4;
   localparam int CLASS_W     = 2;

   // features and centroid registers are one byte each
   localparam int FEATURE_W = 8;
   localparam int CSR_IDX_W = 3;

   // exact squared distance: two squares of at most 255, summed
   localparam int DIFF_W = FEATURE_W + 1;
   localparam int SQ_W   = 2 * FEATURE_W;
   localparam int DIST_W = SQ_W + 1;

   typedef logic [DIST_W-1:0] dist_type;

   typedef enum logic [CLASS_W-1:0] {
      CLASS_SQUARE = 2'd0,
      CLASS_PLAIN  = 2'd1,
      CLASS_RIGHT  = 2'd2,
      CLASS_LEFT   = 2'd3
   } class_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SQUARE_BRIGHTNESS = 3'd0,
      CSR_SQUARE_SHIFTS     = 3'd1,
      CSR_PLAIN_BRIGHTNESS  = 3'd2,
      CSR_PLAIN_SHIFTS      = 3'd3,
      CSR_RIGHT_BRIGHTNESS  = 3'd4,
      CSR_RIGHT_SHIFTS      = 3'd5,
      CSR_LEFT_BRIGHTNESS   = 3'd6,
      CSR_LEFT_SHIFTS       = 3'd7
   } csr_index_type;

   // centroid reset value
   localparam logic [FEATURE_W-1:0] CENTROID_RESET = 8'd1;

   // ones in a row of up to SENSOR_MAX sensors
   function automatic logic [$clog2(SENSOR_MAX+1)-1:0] count_ones(
      input logic [SENSOR_MAX-1:0] bits
   );
      logic [$clog2(SENSOR_MAX+1)-1:0] n;
      n = '0;
      for (int i = 0; i < SENSOR_MAX; i++) begin
         n = n + {{($clog2(SENSOR_MAX+1)-1){1'b0}}, bits[i]};
      end
      return n;
   endfunction

endpackage : rwtc_pkg

`default_nettype wire

@@ sv/row_window_track_classifier.sv @@
// Pipeline: an accepted row moves through registered stages before its result beat
//   shows on rsp_; features load on the accepting edge, then distances, then class.
// Throughput: one row per cycle unless stalled; running sums update per row.
// The first WINDOW_ROWS-1 rows after reset fill the window and give no beat.
// Reset (synchronous, active high) clears the window, both running sums, the
//   fill counter and the pipeline; every centroid register returns to 1.
// ----------------------------------------------------------------------------
// row_window_track_classifier - sliding window track event classifier
// Keeps the last WINDOW_ROWS sensor rows, tracks window brightness and shift
// count as running sums and picks the nearest of four programmable centroids.
// ----------------------------------------------------------------------------
`default_nettype none

module row_window_track_classifier
   import rwtc_pkg::*;
#(
   parameter int WINDOW_ROWS  = DEF_WINDOW_ROWS,
   parameter int SENSOR_COUNT = DEF_SENSOR_COUNT
) (
   input  wire                         clock,
   input  wire                         reset,
   // sensor rows
   input  wire                         req_valid,
   output logic                        req_stall,
   input  wire [SENSOR_COUNT-1:0]      req_sensor_row,
   // classified beats
   output logic                        rsp_valid,
   input  wire                         rsp_stall,
   output logic [CLASS_W-1:0]          rsp_event_class,
   output logic signed [FEATURE_W-1:0] rsp_brightness,
   output logic [FEATURE_W-1:0]        rsp_shift_count,
   // centroid registers
   input  wire                         csr_write,
   input  wire [CSR_IDX_W-1:0]         csr_index,
   input  wire [FEATURE_W-1:0]         csr_wdata
);

   // ------------------------------------------------------------------------
   // Geometry. Sums are kept at full width and saturated to a byte on the
   // way out; at least nine bits so the saturation limits are representable.
   // ------------------------------------------------------------------------
   localparam int LOW_SENSORS  = SENSOR_COUNT / 2;
   localparam int HIGH_SENSORS = SENSOR_COUNT - LOW_SENSORS;
   localparam int BRIGHT_RAW_W = $clog2(WINDOW_ROWS * SENSOR_COUNT + 1) + 1;
   localparam int BRIGHT_W     = (BRIGHT_RAW_W > DIFF_W) ? BRIGHT_RAW_W : DIFF_W;
   localparam int SHIFT_RAW_W  = $clog2((WINDOW_ROWS - 1) * SENSOR_COUNT + 1);
   localparam int SHIFT_W      = (SHIFT_RAW_W > DIFF_W) ? SHIFT_RAW_W : DIFF_W;
   localparam int WARM_W       = (WINDOW_ROWS > 2) ? $clog2(WINDOW_ROWS) : 1;
   localparam int ONES_W       = $clog2(SENSOR_MAX + 1);

   localparam logic [WARM_W-1:0] WARM_LAST = WARM_W'(WINDOW_ROWS - 1);
   localparam logic [SENSOR_COUNT-1:0] LOW_MASK = SENSOR_COUNT'((1 << LOW_SENSORS) - 1);

   localparam logic signed [BRIGHT_W-1:0] BRIGHT_SAT_HI = BRIGHT_W'(127);
   localparam logic signed [BRIGHT_W-1:0] BRIGHT_SAT_LO = BRIGHT_W'(-128);
   localparam logic [SHIFT_W-1:0]         SHIFT_SAT_HI  = SHIFT_W'(255);

   // bounds of the running sums, used by the checks below
   localparam logic signed [BRIGHT_W-1:0] BRIGHT_SUM_HI = BRIGHT_W'(WINDOW_ROWS * LOW_SENSORS);
   localparam logic signed [BRIGHT_W-1:0] BRIGHT_SUM_LO =
      BRIGHT_W'(-(WINDOW_ROWS * HIGH_SENSORS));
   localparam logic [SHIFT_W-1:0] SHIFT_SUM_HI = SHIFT_W'((WINDOW_ROWS - 1) * SENSOR_COUNT);

   // ------------------------------------------------------------------------
   // Centroid registers
   // ------------------------------------------------------------------------
   logic signed [FEATURE_W-1:0] cent_bright_ff [CLASS_COUNT];
   logic [FEATURE_W-1:0]        cent_shift_ff  [CLASS_COUNT];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < CLASS_COUNT; k++) begin
            cent_bright_ff[k] <= CENTROID_RESET;
            cent_shift_ff[k]  <= CENTROID_RESET;
         end
      end else if (csr_write) begin
         case (csr_index_type'(csr_index))
            CSR_SQUARE_BRIGHTNESS: cent_bright_ff[CLASS_SQUARE] <= csr_wdata;
            CSR_SQUARE_SHIFTS:     cent_shift_ff[CLASS_SQUARE]  <= csr_wdata;
            CSR_PLAIN_BRIGHTNESS:  cent_bright_ff[CLASS_PLAIN]  <= csr_wdata;
            CSR_PLAIN_SHIFTS:      cent_shift_ff[CLASS_PLAIN]   <= csr_wdata;
            CSR_RIGHT_BRIGHTNESS:  cent_bright_ff[CLASS_RIGHT]  <= csr_wdata;
            CSR_RIGHT_SHIFTS:      cent_shift_ff[CLASS_RIGHT]   <= csr_wdata;
            CSR_LEFT_BRIGHTNESS:   cent_bright_ff[CLASS_LEFT]   <= csr_wdata;
            CSR_LEFT_SHIFTS:       cent_shift_ff[CLASS_LEFT]    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // ------------------------------------------------------------------------
   // Flow control: each stage takes a new beat when it is empty or when the
   // stage after it moves on, so bubbles are squeezed out under a stall.
   // ------------------------------------------------------------------------
   logic feat_valid_ff, dist_valid_ff, rsp_valid_ff;
   logic out_ready, dist_ready, feat_ready, req_accept;

   assign out_ready  = !rsp_valid_ff || !rsp_stall;
   assign dist_ready = !dist_valid_ff || out_ready;
   assign feat_ready = !feat_valid_ff || dist_ready;
   assign req_stall  = !feat_ready;
   assign req_accept = req_valid && feat_ready;

   // ------------------------------------------------------------------------
   // Window and running sums. Index 0 holds the newest row. Entering a row
   // adds its brightness and its difference to the previous newest row;
   // the row falling out takes its brightness and its last pair with it.
   // ------------------------------------------------------------------------
   logic [SENSOR_COUNT-1:0]     row_window_ff [WINDOW_ROWS];
   logic signed [BRIGHT_W-1:0]  bright_sum_ff, bright_sum_in;
   logic [SHIFT_W-1:0]          shift_sum_ff, shift_sum_in;
   logic [WARM_W-1:0]           warmup_count_ff, warmup_count_in;
   logic                        warm;

   logic [ONES_W-1:0] new_lo, new_hi, old_lo, old_hi, pair_new, pair_old;
   logic [SENSOR_COUNT-1:0] oldest;

   assign oldest = row_window_ff[WINDOW_ROWS-1];
   assign warm   = (warmup_count_ff == WARM_LAST);

   always_comb begin
      new_lo   = count_ones(SENSOR_MAX'(req_sensor_row & LOW_MASK));
      new_hi   = count_ones(SENSOR_MAX'(req_sensor_row & ~LOW_MASK));
      old_lo   = count_ones(SENSOR_MAX'(oldest & LOW_MASK));
      old_hi   = count_ones(SENSOR_MAX'(oldest & ~LOW_MASK));
      pair_new = count_ones(SENSOR_MAX'(req_sensor_row ^ row_window_ff[0]));
      pair_old = count_ones(SENSOR_MAX'(row_window_ff[WINDOW_ROWS-2] ^ oldest));

      bright_sum_in = bright_sum_ff + BRIGHT_W'(new_lo) - BRIGHT_W'(new_hi)
                      - BRIGHT_W'(old_lo) + BRIGHT_W'(old_hi);
      shift_sum_in  = shift_sum_ff + SHIFT_W'(pair_new) - SHIFT_W'(pair_old);
      warmup_count_in = warm ? warmup_count_ff : warmup_count_ff + 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < WINDOW_ROWS; k++) begin
            row_window_ff[k] <= '0;
         end
         bright_sum_ff   <= '0;
         shift_sum_ff    <= '0;
         warmup_count_ff <= '0;
      end else if (req_accept) begin
         row_window_ff[0] <= req_sensor_row;
         for (int k = 1; k < WINDOW_ROWS; k++) begin
            row_window_ff[k] <= row_window_ff[k-1];
         end
         bright_sum_ff   <= bright_sum_in;
         shift_sum_ff    <= shift_sum_in;
         warmup_count_ff <= warmup_count_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 1: byte-saturated features of the updated window
   // ------------------------------------------------------------------------
   logic signed [FEATURE_W-1:0] feat_bright_ff, feat_bright_in;
   logic [FEATURE_W-1:0]        feat_shift_ff, feat_shift_in;

   always_comb begin
      if (bright_sum_in > BRIGHT_SAT_HI) begin
         feat_bright_in = BRIGHT_SAT_HI[FEATURE_W-1:0];
      end else if (bright_sum_in < BRIGHT_SAT_LO) begin
         feat_bright_in = BRIGHT_SAT_LO[FEATURE_W-1:0];
      end else begin
         feat_bright_in = bright_sum_in[FEATURE_W-1:0];
      end
      if (shift_sum_in > SHIFT_SAT_HI) begin
         feat_shift_in = SHIFT_SAT_HI[FEATURE_W-1:0];
      end else begin
         feat_shift_in = shift_sum_in[FEATURE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         feat_valid_ff <= 1'b0;
      end else if (feat_ready) begin
         feat_valid_ff <= req_accept && warm;
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && feat_ready) begin
         feat_bright_ff <= feat_bright_in;
         feat_shift_ff  <= feat_shift_in;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 2: exact squared distance to each centroid (one square per axis)
   // ------------------------------------------------------------------------
   dist_type                    dist_ff [CLASS_COUNT];
   dist_type                    dist_in [CLASS_COUNT];
   logic signed [FEATURE_W-1:0] dist_bright_ff;
   logic [FEATURE_W-1:0]        dist_shift_ff;

   always_comb begin
      logic signed [DIFF_W-1:0]   db, ds;
      logic signed [2*DIFF_W-1:0] sq_b, sq_s;
      for (int k = 0; k < CLASS_COUNT; k++) begin
         db   = {cent_bright_ff[k][FEATURE_W-1], cent_bright_ff[k]}
                - {feat_bright_ff[FEATURE_W-1], feat_bright_ff};
         ds   = {1'b0, cent_shift_ff[k]} - {1'b0, feat_shift_ff};
         sq_b = db * db;
         sq_s = ds * ds;
         dist_in[k] = {1'b0, sq_b[SQ_W-1:0]} + {1'b0, sq_s[SQ_W-1:0]};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dist_valid_ff <= 1'b0;
      end else if (dist_ready) begin
         dist_valid_ff <= feat_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (dist_ready && feat_valid_ff) begin
         for (int k = 0; k < CLASS_COUNT; k++) begin
            dist_ff[k] <= dist_in[k];
         end
         dist_bright_ff <= feat_bright_ff;
         dist_shift_ff  <= feat_shift_ff;
      end
   end

   // ------------------------------------------------------------------------
   // Stage 3: nearest centroid; a strict compare keeps the lower class on a tie
   // ------------------------------------------------------------------------
   logic [CLASS_W-1:0]          best_class;
   logic [CLASS_W-1:0]          rsp_class_ff;
   logic signed [FEATURE_W-1:0] rsp_bright_ff;
   logic [FEATURE_W-1:0]        rsp_shift_ff;

   always_comb begin
      dist_type best_dist;
      best_dist  = dist_ff[0];
      best_class = CLASS_SQUARE;
      for (int k = 1; k < CLASS_COUNT; k++) begin
         if (dist_ff[k] < best_dist) begin
            best_dist  = dist_ff[k];
            best_class = CLASS_W'(k);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (out_ready) begin
         rsp_valid_ff <= dist_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (out_ready && dist_valid_ff) begin
         rsp_class_ff  <= best_class;
         rsp_bright_ff <= dist_bright_ff;
         rsp_shift_ff  <= dist_shift_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_event_class = rsp_class_ff;
   assign rsp_brightness  = rsp_bright_ff;
   assign rsp_shift_count = rsp_shift_ff;

   // ------------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------------
   // features only enter the pipe once the window is full
   a_feat_after_fill: assert property (@(posedge clock) disable iff (reset)
      feat_valid_ff |-> warm)
      else $error("feature beat before window full");

   // running brightness stays within what the window can hold
   a_bright_bound: assert property (@(posedge clock) disable iff (reset)
      (bright_sum_ff <= BRIGHT_SUM_HI) && (bright_sum_ff >= BRIGHT_SUM_LO))
      else $error("running brightness out of range");

   // running shift count stays within what the window can hold
   a_shift_bound: assert property (@(posedge clock) disable iff (reset)
      shift_sum_ff <= SHIFT_SUM_HI)
      else $error("running shift count out of range");

   // a blocked distance beat is held, not dropped
   a_dist_hold: assert property (@(posedge clock) disable iff (reset)
      dist_valid_ff && !out_ready |=> dist_valid_ff && $stable(dist_shift_ff))
      else $error("distance beat lost under stall");

   // the fill counter never passes its last value
   a_warm_sat: assert property (@(posedge clock) disable iff (reset)
      warm |=> warm)
      else $error("fill counter left saturation");

endmodule : row_window_track_classifier

`default_nettype wire
